[design/mawu_pkg.sv]
// shared types and constants for the moving-average warm-up unit
package mawu_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 6;
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0]  WINDOW_LENGTH_RESET = 6'd8;
  localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH  = 3'd0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } mawu_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_last;
  } mawu_status_t;

endpackage

[design/mawu_ram.sv]
// generic simple dual-port ram with registered read
module mawu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mawu_ctrl.sv]
// controller state machine for the moving-average warm-up unit
module mawu_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mawu_pkg::mawu_cmd_t    cmd,
  input  mawu_pkg::mawu_status_t status
);
  import mawu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.update   = (state_r == S_UPDATE);
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd.load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/mawu_dp.sv]
// datapath: ring pointer, running sum, serial divider and result register
module mawu_dp #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         restart,
  input  logic [mawu_pkg::CFG_W-1:0]                   window_length,
  input  logic [mawu_pkg::DATA_W-1:0]                  in_sample,
  input  mawu_pkg::mawu_cmd_t                          cmd,
  output mawu_pkg::mawu_status_t                       status,
  output logic                                         ram_we,
  output logic                                         ram_re,
  output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ram_addr,
  output logic [mawu_pkg::DATA_W-1:0]                  ram_wdata,
  input  logic [mawu_pkg::DATA_W-1:0]                  ram_rdata,
  output logic signed [mawu_pkg::DATA_W-1:0]           out_average
);
  import mawu_pkg::*;

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = DATA_W + $clog2(WINDOW_MAX) + 1;
  localparam int NW    = $clog2(SUM_W + 1);
  localparam logic [8:0]    WMAX9     = 9'(WINDOW_MAX);
  localparam logic [NW-1:0] DIV_STEPS = NW'(SUM_W);

  logic [DATA_W-1:0]       sample_r;
  logic [CW-1:0]           idx_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]           wp_r, wp_nxt;
  logic                    warmed_r, warmed_nxt;
  logic [SUM_W-1:0]        q_r;
  logic [CW-1:0]           rem_r;
  logic [CW-1:0]           div_r;
  logic                    neg_r;
  logic [NW-1:0]           div_cnt_r;
  logic [DATA_W-1:0]       out_average_r;

  logic [8:0]              wl9;
  logic [CW-1:0]           len;
  logic [CW-1:0]           idx_n;
  logic [CW-1:0]           wp_inc;
  logic [CW-1:0]           count;
  logic signed [SUM_W-1:0] s_ext, old_ext;
  logic [CW:0]             trial;
  logic                    take;
  logic [SUM_W-1:0]        q_signed;

  // effective length: zero acts as one, large values saturate
  always_comb begin
    wl9 = {3'b000, window_length};
    if (wl9 == 9'd0) begin
      len = CW'(1);
    end else if (wl9 > WMAX9) begin
      len = CW'(WINDOW_MAX);
    end else begin
      len = CW'(wl9);
    end
  end

  assign idx_n = (wp_r >= len) ? '0 : wp_r;

  // old entry is read on accept, rewritten during the update cycle
  assign ram_re    = cmd.accept;
  assign ram_we    = cmd.update;
  assign ram_addr  = cmd.accept ? idx_n[AW-1:0] : idx_r[AW-1:0];
  assign ram_wdata = sample_r;

  assign s_ext   = {{(SUM_W-DATA_W){sample_r[DATA_W-1]}}, sample_r};
  assign old_ext = {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
  assign wp_inc  = idx_r + CW'(1);

  always_comb begin
    sum_nxt    = sum_r;
    wp_nxt     = wp_r;
    warmed_nxt = warmed_r;
    count      = len;
    if (!warmed_r) begin
      sum_nxt = sum_r + s_ext;
      count   = wp_inc;
      if (wp_inc >= len) begin
        warmed_nxt = 1'b1;
        wp_nxt     = '0;
      end else begin
        wp_nxt = wp_inc;
      end
    end else begin
      sum_nxt = sum_r - old_ext + s_ext;
      wp_nxt  = wp_inc;
    end
  end

  // restoring divider, one quotient bit per step
  assign trial = {rem_r, q_r[SUM_W-1]};
  assign take  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      wp_r      <= '0;
      warmed_r  <= 1'b0;
      div_cnt_r <= '0;
    end else if (restart) begin
      sum_r    <= '0;
      wp_r     <= '0;
      warmed_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        sum_r     <= sum_nxt;
        wp_r      <= wp_nxt;
        warmed_r  <= warmed_nxt;
        div_cnt_r <= DIV_STEPS;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      idx_r    <= idx_n;
    end
    if (cmd.update) begin
      q_r   <= sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
      neg_r <= sum_nxt[SUM_W-1];
      rem_r <= '0;
      div_r <= count;
    end else if (cmd.div_step) begin
      q_r   <= {q_r[SUM_W-2:0], take};
      rem_r <= take ? CW'(trial - {1'b0, div_r}) : trial[CW-1:0];
    end
    if (cmd.load_out) begin
      out_average_r <= q_signed[DATA_W-1:0];
    end
  end

  assign q_signed        = neg_r ? (~q_r + SUM_W'(1)) : q_r;
  assign status.div_last = (div_cnt_r == NW'(1));
  assign out_average     = out_average_r;

endmodule

[design/moving_average_warmup_unit.sv]
// top level of the moving-average warm-up unit: config register and submodules
// an accepted input beat passes through the sum update and the serial divider,
//   one quotient bit per cycle over the running sum, before its result reaches out_valid
// a new input beat is taken only once the last result has gone to the output
//   register; a result waiting there does not block the next input beat
// reset: window_length returns to 8, running sum, ring pointer and warm-up flag
//   clear; ring storage is not cleared, a read entry is only used once written
module moving_average_warmup_unit #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mawu_pkg::DATA_W-1:0]  in_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mawu_pkg::DATA_W-1:0]  out_average,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mawu_pkg::ADDR_W-1:0]         paddr,
  input  logic [mawu_pkg::APB_W-1:0]          pwdata,
  output logic [mawu_pkg::APB_W-1:0]          prdata,
  output logic                                pready
);
  import mawu_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CFG_W-1:0]  window_length_r;
  logic              reg_sel;
  logic              cfg_write;
  mawu_cmd_t         cmd;
  mawu_status_t      status;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // register decode: only the word at offset zero exists
  assign pready    = 1'b1;
  assign reg_sel   = (paddr == ADDR_WINDOW_LENGTH);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_LENGTH_RESET;
    end else if (cfg_write) begin
      window_length_r <= pwdata[CFG_W-1:0];
    end
  end

  // reads of any other word return zero
  assign prdata = reg_sel ? {{(APB_W-CFG_W){1'b0}}, window_length_r} : '0;

  // sequencing: accept, sum update, serial divide, hand to output register
  mawu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // a register write restarts warm-up
  mawu_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .restart       (cfg_write),
    .window_length (window_length_r),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .status        (status),
    .ram_we        (ram_we),
    .ram_re        (ram_re),
    .ram_addr      (ram_addr),
    .ram_wdata     (ram_wdata),
    .ram_rdata     (ram_rdata),
    .out_average   (out_average)
  );

  // ring of the most recent samples; read and write never share a cycle
  mawu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

endmodule
